FILE: rtl/crqs_pkg.sv
// shared types and constants for the cigar region to query span block
package crqs_pkg;

   // cigar operation codes
   localparam logic [3:0] OP_MATCH    = 4'd0;
   localparam logic [3:0] OP_INS      = 4'd1;
   localparam logic [3:0] OP_DEL      = 4'd2;
   localparam logic [3:0] OP_SKIP     = 4'd3;
   localparam logic [3:0] OP_SOFTCLIP = 4'd4;
   localparam logic [3:0] OP_HARDCLIP = 4'd5;
   localparam logic [3:0] OP_PAD      = 4'd6;
   localparam logic [3:0] OP_SEQ_EQ   = 4'd7;
   localparam logic [3:0] OP_SEQ_DIFF = 4'd8;

   // configuration register indexes
   localparam logic [1:0] REG_WINDOW_START = 2'd0;
   localparam logic [1:0] REG_WINDOW_END   = 2'd1;
   localparam logic [1:0] REG_ZERO_BASED   = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned POS_W       = 31;
   localparam int unsigned CODE_W      = 4;
   localparam int unsigned LEN_W       = 28;
   localparam int unsigned RUN_W       = 32;
   localparam int unsigned SPAN_W      = 34;
   localparam int unsigned REQ_DATA_W  = 64;
   localparam int unsigned RSP_DATA_W  = 64;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_END   = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [POS_W-1:0] window_start;
      logic [POS_W-1:0] window_end;
      logic             zero_based;
   } cfg_type;

   typedef struct packed {
      logic              first_op;
      logic [POS_W-1:0]  record_ref_pos;
      logic [CODE_W-1:0] op_code;
      logic [LEN_W-1:0]  op_length;
      logic              last_op;
   } op_item_type;

   typedef struct packed {
      logic             span_found;
      logic [POS_W-1:0] query_start;
      logic [POS_W-1:0] query_end;
   } result_type;

endpackage

FILE: rtl/cigar_region_to_query_span_core.sv
// Maps a reference window onto query coordinates from a stream of CIGAR ops.
// One op is taken per clock cycle while the input register is not held by a
// stalled closing op: an accepted op sits in an input register, where the
// walk logic updates the running reference/query positions and search phase;
// the op flagged with tlast then loads a result register, so a result passes
// through the input register and then the result register. Each record's last
// op yields exactly one result; all other ops yield none. A waiting result
// stalls only an op that closes a record; other ops keep flowing. Configuration
// writes take effect on the next op and must be made while no op is in flight.
module cigar_region_to_query_span_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // op stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // record_ref_pos [30:0], op_code [34:31], op_length [62:35], zero [63]
   input  logic [crqs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // first_op [0]
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   // span result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // query_start [30:0], query_end [61:31], zero [63:62]
   output logic [crqs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // span_found [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crqs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crqs_pkg::POS_W-1:0]           csr_data
);

   crqs_pkg::cfg_type     cfg;
   crqs_pkg::op_item_type req_item;
   crqs_pkg::op_item_type item_ff;
   logic                  item_valid_ff, item_valid_in;
   crqs_pkg::result_type  walk_result;
   crqs_pkg::result_type  rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;
   logic                  step_en;
   logic                  req_accept;

   crqs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // unpack the incoming transaction
   always_comb begin
      req_item.first_op       = req_tuser;
      req_item.record_ref_pos = req_tdata[30:0];
      req_item.op_code        = req_tdata[34:31];
      req_item.op_length      = req_tdata[62:35];
      req_item.last_op        = req_tlast;
   end

   // flow control: only a record-closing op needs a free result slot
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = item_valid_ff && (!item_ff.last_op || out_free);
   assign req_tready = !item_valid_ff || step_en;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (step_en) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   crqs_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (walk_result)
   );

   // result register valid
   always_comb begin
      if (step_en && item_ff.last_op) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
      end
      if (step_en && item_ff.last_op) begin
         rsp_ff <= walk_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.query_end, rsp_ff.query_start};
   assign rsp_tuser  = rsp_ff.span_found;
   assign rsp_tlast  = 1'b1;

endmodule

FILE: rtl/crqs_csr.sv
// configuration registers for the reference window
module crqs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crqs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crqs_pkg::POS_W-1:0]           csr_data,
   output crqs_pkg::cfg_type                    cfg
);

   crqs_pkg::cfg_type cfg_ff;
   crqs_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            crqs_pkg::REG_WINDOW_START: cfg_in.window_start = csr_data;
            crqs_pkg::REG_WINDOW_END:   cfg_in.window_end   = csr_data;
            crqs_pkg::REG_ZERO_BASED:   cfg_in.zero_based   = csr_data[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/crqs_walk.sv
// running reference/query walk over cigar ops and span boundary search
module crqs_walk (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  crqs_pkg::op_item_type    item,
   input  crqs_pkg::cfg_type        cfg,
   output crqs_pkg::result_type     result
);

   localparam int unsigned RUN_W  = crqs_pkg::RUN_W;
   localparam int unsigned SPAN_W = crqs_pkg::SPAN_W;
   localparam int unsigned POS_W  = crqs_pkg::POS_W;

   logic [RUN_W-1:0]         ref_ff, ref_in;
   logic [RUN_W-1:0]         query_ff, query_in;
   crqs_pkg::phase_type      phase_ff, phase_in;
   logic signed [SPAN_W-1:0] span_start_ff, span_start_in;
   logic signed [SPAN_W-1:0] span_end_ff, span_end_in;
   logic                     covers_ff, covers_in;

   logic [RUN_W-1:0]         ref_base;
   logic [RUN_W-1:0]         query_base;
   crqs_pkg::phase_type      phase_base;
   logic signed [SPAN_W-1:0] start_target;
   logic signed [SPAN_W-1:0] end_target;
   logic [RUN_W:0]           reach;
   logic [RUN_W:0]           query_sum;
   logic                     hit_start;
   logic                     hit_end;
   logic                     is_match;
   logic                     is_del;
   logic                     is_qonly;
   logic signed [SPAN_W-1:0] query_minus_ref;
   logic signed [SPAN_W-1:0] start_val;
   logic signed [SPAN_W-1:0] end_val;
   logic [RUN_W-1:0]         ref_adv;
   logic [RUN_W-1:0]         query_adv;
   logic                     found;

   // window start in zero-based terms, may be minus one
   always_comb begin
      start_target = $signed({{(SPAN_W-POS_W){1'b0}}, cfg.window_start});
      if (!cfg.zero_based) begin
         start_target = start_target - SPAN_W'(1);
      end
      end_target = $signed({{(SPAN_W-POS_W){1'b0}}, cfg.window_end});
   end

   // a first op restarts the record before the op itself is applied
   always_comb begin
      if (item.first_op) begin
         ref_base   = {1'b0, item.record_ref_pos};
         query_base = '0;
         phase_base = crqs_pkg::PH_START;
      end else begin
         ref_base   = ref_ff;
         query_base = query_ff;
         phase_base = phase_ff;
      end
   end

   // op classes
   always_comb begin
      is_match = (item.op_code == crqs_pkg::OP_MATCH) ||
                 (item.op_code == crqs_pkg::OP_SEQ_EQ) ||
                 (item.op_code == crqs_pkg::OP_SEQ_DIFF);
      is_del   = (item.op_code == crqs_pkg::OP_DEL) || (item.op_code == crqs_pkg::OP_SKIP);
      is_qonly = (item.op_code == crqs_pkg::OP_INS) ||
                 (item.op_code == crqs_pkg::OP_SOFTCLIP);
   end

   // reach of this op and boundary tests
   always_comb begin
      reach     = {1'b0, ref_base} + {{(RUN_W+1-crqs_pkg::LEN_W){1'b0}}, item.op_length};
      query_sum = {1'b0, query_base} + {{(RUN_W+1-crqs_pkg::LEN_W){1'b0}}, item.op_length};
      hit_start = $signed({1'b0, reach}) > start_target;
      hit_end   = $signed({1'b0, reach}) > end_target;
      ref_adv   = reach[RUN_W] ? {RUN_W{1'b1}} : reach[RUN_W-1:0];
      query_adv = query_sum[RUN_W] ? {RUN_W{1'b1}} : query_sum[RUN_W-1:0];
   end

   // query offset of a boundary inside a match op, or query position for gaps
   always_comb begin
      query_minus_ref = $signed({2'b00, query_base}) - $signed({2'b00, ref_base});
      if (is_match) begin
         start_val = query_minus_ref + start_target;
         end_val   = query_minus_ref + end_target;
      end else begin
         start_val = $signed({2'b00, query_base});
         end_val   = $signed({2'b00, query_base});
      end
   end

   // next state
   always_comb begin
      ref_in        = ref_base;
      query_in      = query_base;
      phase_in      = phase_base;
      span_start_in = item.first_op ? '0 : span_start_ff;
      span_end_in   = item.first_op ? '0 : span_end_ff;
      covers_in     = item.first_op ?
                      ($signed({3'b000, item.record_ref_pos}) <= start_target) : covers_ff;
      if (phase_base != crqs_pkg::PH_DONE) begin
         if (is_match || is_del) begin
            case (phase_base)
               crqs_pkg::PH_START: begin
                  if (hit_start) begin
                     span_start_in = start_val;
                     if (hit_end) begin
                        span_end_in = end_val;
                        phase_in    = crqs_pkg::PH_DONE;
                     end else begin
                        phase_in = crqs_pkg::PH_END;
                        ref_in   = ref_adv;
                        if (is_match) query_in = query_adv;
                     end
                  end else begin
                     ref_in = ref_adv;
                     if (is_match) query_in = query_adv;
                  end
               end
               crqs_pkg::PH_END: begin
                  if (hit_end) begin
                     span_end_in = end_val;
                     phase_in    = crqs_pkg::PH_DONE;
                  end else begin
                     ref_in = ref_adv;
                     if (is_match) query_in = query_adv;
                  end
               end
               default: phase_in = phase_base;
            endcase
         end else if (is_qonly) begin
            query_in = query_adv;
         end
      end
   end

   // result of the record, offsets clamped into the output range
   always_comb begin
      found = covers_in && (phase_in == crqs_pkg::PH_DONE) && (span_end_in > span_start_in);
      result.span_found  = found;
      result.query_start = '0;
      result.query_end   = '0;
      if (found) begin
         if (span_start_in < 0) begin
            result.query_start = '0;
         end else if (span_start_in[SPAN_W-2:POS_W] != '0) begin
            result.query_start = {POS_W{1'b1}};
         end else begin
            result.query_start = span_start_in[POS_W-1:0];
         end
         if (span_end_in < 0) begin
            result.query_end = '0;
         end else if (span_end_in[SPAN_W-2:POS_W] != '0) begin
            result.query_end = {POS_W{1'b1}};
         end else begin
            result.query_end = span_end_in[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff        <= '0;
         query_ff      <= '0;
         phase_ff      <= crqs_pkg::PH_START;
         span_start_ff <= '0;
         span_end_ff   <= '0;
         covers_ff     <= 1'b0;
      end else if (step_en) begin
         ref_ff        <= ref_in;
         query_ff      <= query_in;
         phase_ff      <= phase_in;
         span_start_ff <= span_start_in;
         span_end_ff   <= span_end_in;
         covers_ff     <= covers_in;
      end
   end

endmodule

FILE: bench/cigar_region_to_query_span_core_tb.sv
// testbench for cigar_region_to_query_span_core: cigar op streams with window mapping checks
`timescale 1ns / 100ps

module cigar_region_to_query_span_core_tb;

   localparam int unsigned POS_W       = crqs_pkg::POS_W;
   localparam int unsigned LEN_W       = crqs_pkg::LEN_W;
   localparam int unsigned CODE_W      = crqs_pkg::CODE_W;
   localparam int unsigned RUN_W       = crqs_pkg::RUN_W;
   localparam int unsigned CSR_INDEX_W = crqs_pkg::CSR_INDEX_W;
   localparam int unsigned REQ_DATA_W  = crqs_pkg::REQ_DATA_W;
   localparam int unsigned RSP_DATA_W  = crqs_pkg::RSP_DATA_W;

   localparam logic [POS_W-1:0] SPAN_MAX    = '1;
   localparam logic [LEN_W-1:0] LEN_MAX     = '1;
   localparam int unsigned      HOLD_AFTER  = 20;
   localparam int unsigned      HOLD_PHASE  = 4;
   localparam int unsigned      HOLD_CYCLES = 300;
   localparam int unsigned      PHASE_OPS   = 80;
   localparam int unsigned      N_PHASES    = 9;

   // span predictor plus queue of expected spans
   class span_scoreboard;
      logic [POS_W-1:0]     win_start;
      logic [POS_W-1:0]     win_end;
      logic                 zero_based;
      logic [RUN_W-1:0]     ref_pos;
      logic [RUN_W-1:0]     query_pos;
      crqs_pkg::phase_type  phase;
      longint               span_start;
      longint               span_end;
      bit                   covers;
      crqs_pkg::result_type pending_spans[$];
      int unsigned          errors;
      int unsigned          checked;

      function new();
         win_start  = '0;
         win_end    = '0;
         zero_based = 1'b0;
         ref_pos    = '0;
         query_pos  = '0;
         phase      = crqs_pkg::PH_START;
         span_start = 0;
         span_end   = 0;
         covers     = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      function longint wide(logic [31:0] v);
         return longint'({32'd0, v});
      endfunction

      function longint start_target();
         return zero_based ? wide(RUN_W'(win_start)) : wide(RUN_W'(win_start)) - 1;
      endfunction

      function logic [RUN_W-1:0] sat_add(logic [RUN_W-1:0] a, logic [RUN_W-1:0] b);
         logic [RUN_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[RUN_W] ? '1 : s[RUN_W-1:0];
      endfunction

      function logic [POS_W-1:0] clamp_out(longint v);
         if (v < 0) return '0;
         if (v > 64'sh7FFF_FFFF) return SPAN_MAX;
         return v[POS_W-1:0];
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [POS_W-1:0] data);
         case (idx)
            crqs_pkg::REG_WINDOW_START: win_start = data;
            crqs_pkg::REG_WINDOW_END:   win_end = data;
            crqs_pkg::REG_ZERO_BASED:   zero_based = data[0];
            default: ;
         endcase
      endfunction

      // a boundary settles start first, then end
      function void settle(longint value);
         if (phase == crqs_pkg::PH_START) begin
            span_start = value;
            phase = crqs_pkg::PH_END;
         end else begin
            span_end = value;
            phase = crqs_pkg::PH_DONE;
         end
      endfunction

      // walk one accepted op; a record's last op queues one span
      function void note_op(crqs_pkg::op_item_type op);
         longint               target;
         longint               reach;
         bit                   is_match;
         bit                   is_gap;
         bit                   found;
         crqs_pkg::result_type res;
         if (op.first_op) begin
            ref_pos    = {1'b0, op.record_ref_pos};
            query_pos  = '0;
            phase      = crqs_pkg::PH_START;
            span_start = 0;
            span_end   = 0;
            covers     = wide(RUN_W'(op.record_ref_pos)) <= start_target();
         end
         is_match = op.op_code == crqs_pkg::OP_MATCH || op.op_code == crqs_pkg::OP_SEQ_EQ ||
                    op.op_code == crqs_pkg::OP_SEQ_DIFF;
         is_gap   = op.op_code == crqs_pkg::OP_DEL || op.op_code == crqs_pkg::OP_SKIP;
         if (phase != crqs_pkg::PH_DONE) begin
            if (is_match || is_gap) begin
               while (phase != crqs_pkg::PH_DONE) begin
                  target = (phase == crqs_pkg::PH_START) ? start_target()
                                                         : wide(RUN_W'(win_end));
                  reach  = wide(ref_pos) + wide(RUN_W'(op.op_length));
                  if (reach > target) begin
                     settle(is_match ? wide(query_pos) + (target - wide(ref_pos))
                                     : wide(query_pos));
                  end else begin
                     if (is_match) query_pos = sat_add(query_pos, RUN_W'(op.op_length));
                     ref_pos = sat_add(ref_pos, RUN_W'(op.op_length));
                     break;
                  end
               end
            end else if (op.op_code == crqs_pkg::OP_INS ||
                         op.op_code == crqs_pkg::OP_SOFTCLIP) begin
               query_pos = sat_add(query_pos, RUN_W'(op.op_length));
            end
         end
         if (op.last_op) begin
            found           = covers && phase == crqs_pkg::PH_DONE && span_end > span_start;
            res.span_found  = found;
            res.query_start = found ? clamp_out(span_start) : '0;
            res.query_end   = found ? clamp_out(span_end) : '0;
            pending_spans.push_back(res);
         end
      endfunction

      function void check_span(logic found, logic [POS_W-1:0] q_start,
                               logic [POS_W-1:0] q_end, logic last_flag);
         crqs_pkg::result_type want;
         checked++;
         if (pending_spans.size() == 0) begin
            $error("unexpected span transaction: found %0d start %0d end %0d",
                   found, q_start, q_end);
            errors++;
            return;
         end
         want = pending_spans.pop_front();
         if (found !== want.span_found) begin
            $error("span_found: expected %0d, got %0d", want.span_found, found);
            errors++;
         end
         if (q_start !== want.query_start) begin
            $error("query_start: expected %0d, got %0d", want.query_start, q_start);
            errors++;
         end
         if (q_end !== want.query_end) begin
            $error("query_end: expected %0d, got %0d", want.query_end, q_end);
            errors++;
         end
         if (last_flag !== 1'b1) begin
            $error("result_last: expected 1, got %0d", last_flag);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [POS_W-1:0]       csr_data;

   span_scoreboard board = new();

   bit          no_idle;
   bit          rsp_holding;
   bit          hold_done;
   int unsigned hold_at_ops = 32'hFFFF_FFFF;
   int unsigned rsp_wait;
   int unsigned spans_taken;
   int unsigned ops_sent;
   int unsigned windows_used;

   cigar_region_to_query_span_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int unsigned next_gap();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   // span receiver: random stalls per transaction, one long hold mid-phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
         rsp_holding = 1'b0;
         hold_done = 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         board.check_span(rsp_tuser, rsp_tdata[30:0], rsp_tdata[61:31], rsp_tlast);
         spans_taken++;
         if (!hold_done && ops_sent >= hold_at_ops) begin
            rsp_wait = HOLD_CYCLES;
            rsp_holding = 1'b1;
            hold_done = 1'b1;
         end else begin
            rsp_wait = next_gap();
         end
         rsp_tready <= (rsp_wait == 0);
      end else if (!rsp_tready) begin
         if (rsp_wait != 0) rsp_wait--;
         if (rsp_wait == 0) rsp_holding = 1'b0;
         rsp_tready <= (rsp_wait == 0);
      end
   end

   function automatic crqs_pkg::op_item_type op_of(logic first, logic [POS_W-1:0] rpos,
                                                   logic [CODE_W-1:0] code,
                                                   logic [LEN_W-1:0] len, logic last);
      crqs_pkg::op_item_type op;
      op.first_op       = first;
      op.record_ref_pos = rpos;
      op.op_code        = code;
      op.op_length      = len;
      op.last_op        = last;
      return op;
   endfunction

   // one op transaction, preceded by a random gap
   task automatic send_op(crqs_pkg::op_item_type op);
      int unsigned gap;
      gap = rsp_holding ? 0 : next_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, op.op_length, op.op_code, op.record_ref_pos};
      req_tuser  <= op.first_op;
      req_tlast  <= op.last_op;
      do @(posedge clock); while (!req_tready);
      board.note_op(op);
      ops_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [POS_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
   endtask

   task automatic apply_window(logic [POS_W-1:0] w_start, logic [POS_W-1:0] w_end,
                               logic zb);
      write_reg(crqs_pkg::REG_WINDOW_START, w_start);
      write_reg(crqs_pkg::REG_WINDOW_END, w_end);
      write_reg(crqs_pkg::REG_ZERO_BASED, {{(POS_W-1){1'b0}}, zb});
      csr_valid <= 1'b0;
      @(posedge clock);
      windows_used++;
   endtask

   // stop offering ops and let every expected span and in-flight op clear
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_spans.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r <= 5) return crqs_pkg::OP_MATCH;
      if (r <= 7) return crqs_pkg::OP_INS;
      if (r <= 9) return crqs_pkg::OP_DEL;
      case (r)
         10: return crqs_pkg::OP_SKIP;
         11: return crqs_pkg::OP_SOFTCLIP;
         12: return crqs_pkg::OP_SEQ_EQ;
         13: return crqs_pkg::OP_SEQ_DIFF;
         14: return crqs_pkg::OP_HARDCLIP;
         15: return crqs_pkg::OP_PAD;
         default: return CODE_W'($urandom_range(9, 15));
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return LEN_W'($urandom);
      if (r == 1) return '0;
      return LEN_W'($urandom_range(1, 40));
   endfunction

   // one record, a noise burst, or a long insertion run
   task automatic send_record();
      int unsigned kind;
      int unsigned n_ops;
      longint      tgt;
      longint      rp;
      kind = $urandom_range(0, 39);
      tgt  = board.start_target();
      case ($urandom_range(0, 9))
         0: rp = longint'($urandom_range(0, 32'h7FFF_FFFF));
         1: rp = tgt + $urandom_range(1, 40);
         default: rp = tgt - $urandom_range(0, 60);
      endcase
      if (rp < 0) rp = 0;
      if (rp > 64'sh7FFF_FFFF) rp = 64'sh7FFF_FFFF;
      if (kind == 0) begin
         // query position runs into saturation
         send_op(op_of(1'b1, rp[30:0], crqs_pkg::OP_SOFTCLIP, LEN_MAX, 1'b0));
         repeat (16) send_op(op_of(1'b0, POS_W'($urandom), crqs_pkg::OP_INS,
                                   LEN_MAX - LEN_W'($urandom_range(0, 3)), 1'b0));
         send_op(op_of(1'b0, POS_W'($urandom), crqs_pkg::OP_MATCH, 28'd200, 1'b1));
      end else if (kind <= 5) begin
         // unstructured ops with random record flags
         n_ops = $urandom_range(1, 4);
         repeat (n_ops)
            send_op(op_of(1'($urandom_range(0, 1)), POS_W'($urandom),
                          CODE_W'($urandom), pick_len(), 1'($urandom_range(0, 1))));
      end else begin
         n_ops = $urandom_range(1, 8);
         for (int i = 0; i < n_ops; i++)
            send_op(op_of(i == 0, (i == 0) ? rp[30:0] : POS_W'($urandom), pick_code(),
                          pick_len(), i == n_ops - 1));
      end
   endtask

   initial begin : stimulus
      logic [POS_W-1:0] w_start;
      logic [POS_W-1:0] w_end;
      longint           w_tmp;
      int unsigned      phase_goal;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= crqs_pkg::REG_WINDOW_START;
      csr_data   <= '0;
      no_idle    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: window 10..30 zero-based
      apply_window(31'd10, 31'd30, 1'b1);
      // one match settles both boundaries
      send_op(op_of(1'b1, 31'd0, crqs_pkg::OP_MATCH, 28'd100, 1'b1));
      // soft clip, insertion, match, deletion and skip, end mapped through a skip, trailing op after done
      send_op(op_of(1'b1, 31'd5, crqs_pkg::OP_SOFTCLIP, 28'd5, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_INS, 28'd3, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_MATCH, 28'd10, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_DEL, 28'd10, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_SKIP, 28'd10, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_SEQ_EQ, 28'd4, 1'b1));
      // record starts after the window start
      send_op(op_of(1'b1, 31'd20, crqs_pkg::OP_SEQ_DIFF, 28'd50, 1'b1));
      // hard clip, pad and unknown codes do nothing
      send_op(op_of(1'b1, 31'd0, crqs_pkg::OP_HARDCLIP, 28'd5, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_PAD, 28'd7, 1'b0));
      send_op(op_of(1'b0, 31'd0, 4'd15, LEN_MAX, 1'b0));
      send_op(op_of(1'b0, 31'd0, 4'd9, 28'd3, 1'b0));
      send_op(op_of(1'b1 ^ 1'b1, 31'd0, crqs_pkg::OP_SEQ_DIFF, 28'd40, 1'b1));
      // walk continues without a new record
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_MATCH, 28'd3, 1'b1));
      // end never reached
      send_op(op_of(1'b1, 31'd0, crqs_pkg::OP_MATCH, 28'd20, 1'b1));
      drain();

      // directed: offsets past the output range clamp
      apply_window(31'h7FFF_FF9C, SPAN_MAX, 1'b1);
      send_op(op_of(1'b1, 31'h7800_0000, crqs_pkg::OP_INS, LEN_MAX, 1'b0));
      repeat (7) send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_INS, LEN_MAX, 1'b0));
      send_op(op_of(1'b0, 31'd0, crqs_pkg::OP_MATCH, LEN_MAX, 1'b1));
      drain();

      // random phases, extremes of the window first
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: apply_window('0, '0, 1'b0);
            1: apply_window(SPAN_MAX, SPAN_MAX, 1'b0);
            2: apply_window('0, SPAN_MAX, 1'b1);
            default: begin
               w_start = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 300))
                                                    : POS_W'($urandom);
               w_tmp = longint'(w_start) + $urandom_range(0, 150) - 20;
               if (w_tmp < 0) w_tmp = 0;
               if (w_tmp > 64'sh7FFF_FFFF) w_tmp = 64'sh7FFF_FFFF;
               w_end = w_tmp[30:0];
               if ($urandom_range(0, 7) == 0) w_end = POS_W'($urandom);
               apply_window(w_start, w_end, 1'($urandom_range(0, 1)));
            end
         endcase
         no_idle = (p % 3 == 2);
         // long receiver hold starts partway into this phase
         if (p == HOLD_PHASE) hold_at_ops = ops_sent + HOLD_AFTER;
         phase_goal = ops_sent + PHASE_OPS;
         while (ops_sent < phase_goal) send_record();
         drain();
      end

      no_idle = 1'b0;
      repeat (10) @(posedge clock);
      $display("Ran %0d cigar ops under %0d window settings", ops_sent, windows_used);
      $display("Compared %0d span results, %0d problems", board.checked, board.errors);
      if (board.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
